FILE: rtl/tspd_pkg.sv
package tspd_pkg;

  // default link lengths, q4.12
  localparam int LINK1_LENGTH_DEF = 4096;
  localparam int LINK2_LENGTH_DEF = 4096;

  // configuration port
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STIFF_XX = 3'd0,
    REG_STIFF_XY = 3'd1,
    REG_STIFF_YX = 3'd2,
    REG_STIFF_YY = 3'd3,
    REG_DAMP_XX  = 3'd4,
    REG_DAMP_XY  = 3'd5,
    REG_DAMP_YX  = 3'd6,
    REG_DAMP_YY  = 3'd7
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd12800, 16'd0, 16'd0, 16'd12800, 16'd5120, 16'd0, 16'd0, 16'd5120
  };

  // cordic
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  // datapath widths
  localparam int TRIG_W = 17;
  localparam int PROD_W = 33;
  localparam int PSUM_W = 34;
  localparam int VM_W   = 50;
  localparam int EP_W   = 26;
  localparam int EV_W   = 31;
  localparam int RJ_W   = 25;
  localparam int GP_W   = 47;
  localparam int DP_W   = 50;
  localparam int GSUM_W = 50;
  localparam int ACC_W  = 42;
  localparam int SPLIT_W = 21;
  localparam int HP_W   = 46;
  localparam int LP_W   = 47;
  localparam int DET_W  = 51;
  localparam int NUM_W  = 68;

  // divider
  localparam int QUO_W      = 31;
  localparam int DIVIDEND_W = 84;
  localparam int CMD_W      = 32;
  localparam logic [CMD_W-1:0] CMD_MAX = 32'h7FFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_MIN = 32'h8000_0000;

  localparam int JOB_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [15:0] joint_angle_1;
    logic signed [15:0] joint_angle_2;
    logic signed [15:0] joint_rate_1;
    logic signed [15:0] joint_rate_2;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_vel_x;
    logic signed [15:0] target_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accel_cmd_1;
    logic signed [31:0] accel_cmd_2;
    logic               singular;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kxx;
    logic signed [GAIN_W-1:0] kxy;
    logic signed [GAIN_W-1:0] kyx;
    logic signed [GAIN_W-1:0] kyy;
    logic signed [GAIN_W-1:0] dxx;
    logic signed [GAIN_W-1:0] dxy;
    logic signed [GAIN_W-1:0] dyx;
    logic signed [GAIN_W-1:0] dyy;
  } gains_t;

  // work handed from front to back
  typedef struct packed {
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
    logic signed [DET_W-1:0] det;
    logic                    singular;
  } job_t;

  typedef enum logic [3:0] {
    F_IDLE, F_CORDIC, F_TRIG, F_PROD, F_VEL, F_ERR, F_GAIN, F_SUM, F_NUMP, F_NUM, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_CHECK, B_DIV, B_OUT
  } back_state_t;

  // arctangent table, 2^32 per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      4'd0:    v = 34'sh20000000;
      4'd1:    v = 34'sh12E4051E;
      4'd2:    v = 34'sh09FB385B;
      4'd3:    v = 34'sh051111D4;
      4'd4:    v = 34'sh028B0D43;
      4'd5:    v = 34'sh0145D7E1;
      4'd6:    v = 34'sh00A2F61E;
      4'd7:    v = 34'sh00517C55;
      4'd8:    v = 34'sh0028BE53;
      4'd9:    v = 34'sh00145F2F;
      4'd10:   v = 34'sh000A2F98;
      4'd11:   v = 34'sh000517CC;
      4'd12:   v = 34'sh00028BE6;
      4'd13:   v = 34'sh000145F3;
      4'd14:   v = 34'sh0000A2F9;
      4'd15:   v = 34'sh0000517C;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tspd_front.sv
module tspd_front #(
  parameter int LINK1_LENGTH = tspd_pkg::LINK1_LENGTH_DEF,
  parameter int LINK2_LENGTH = tspd_pkg::LINK2_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tspd_pkg::in_item_t in_data,
  input  tspd_pkg::gains_t   gains,
  output logic               job_valid,
  input  logic               job_full,
  output tspd_pkg::job_t     job
);
  import tspd_pkg::*;

  localparam logic signed [15:0] L1 = 16'(LINK1_LENGTH);
  localparam logic signed [15:0] L2 = 16'(LINK2_LENGTH);
  localparam int EPT_W = 36;
  localparam int EVT_W = 53;
  localparam int RJT_W = 35;
  localparam logic signed [CORDIC_W-1:0] TRIG_HALF = CORDIC_W'(32768);
  localparam logic signed [EPT_W-1:0]    EP_HALF   = EPT_W'(512);
  localparam logic signed [EVT_W-1:0]    EV_HALF   = EVT_W'(2097152);
  localparam logic signed [RJT_W-1:0]    RJ_HALF   = RJT_W'(512);
  localparam logic signed [GSUM_W-1:0]   ACC_HALF  = GSUM_W'(128);

  front_state_t state_r, state_nxt;
  logic [STEP_W-1:0] iter_r, iter_nxt;
  logic hold_valid_r, hold_valid_nxt;
  in_item_t hold_r, item_r;
  logic start, accept;

  logic signed [CORDIC_W-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic flip1_r, flip2_r;
  logic signed [TRIG_W-1:0] c1_r, s1_r, c12_r, s12_r;
  logic signed [16:0] rsum_r;
  logic signed [PROD_W-1:0] p1c_r, p1s_r, p2c_r, p2s_r;
  logic signed [PSUM_W-1:0] px_r, py_r;
  logic signed [VM_W-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [EP_W-1:0] epx_r, epy_r;
  logic signed [EV_W-1:0] evx_r, evy_r;
  logic signed [RJ_W-1:0] r00_r, r01_r, r10_r, r11_r;
  logic signed [GP_W-1:0] gx1_r, gx2_r, gx3_r, gx4_r, gy1_r, gy2_r, gy3_r, gy4_r;
  logic signed [DP_W-1:0] dp1_r, dp2_r;
  logic signed [ACC_W-1:0] ax_r, ay_r;
  logic signed [DET_W-1:0] det_r;
  logic signed [HP_W-1:0] h11x_r, h01y_r, h00y_r, h10x_r;
  logic signed [LP_W-1:0] l11x_r, l01y_r, l00y_r, l10x_r;
  job_t job_r;

  // angle folding into the right half plane
  logic [15:0] a12;
  logic signed [16:0] a1_ext, a2_ext, a1_fold, a2_fold;
  logic fold1, fold2;

  always_comb begin
    a12 = hold_r.joint_angle_1 + hold_r.joint_angle_2;
    a1_ext = 17'(hold_r.joint_angle_1);
    a2_ext = 17'(signed'(a12));
    fold1 = (a1_ext > 17'sd16384) || (a1_ext < -17'sd16384);
    fold2 = (a2_ext > 17'sd16384) || (a2_ext < -17'sd16384);
    a1_fold = a1_ext;
    a2_fold = a2_ext;
    if (a1_ext > 17'sd16384) begin
      a1_fold = a1_ext - 17'sd32768;
    end else if (a1_ext < -17'sd16384) begin
      a1_fold = a1_ext + 17'sd32768;
    end
    if (a2_ext > 17'sd16384) begin
      a2_fold = a2_ext - 17'sd32768;
    end else if (a2_ext < -17'sd16384) begin
      a2_fold = a2_ext + 17'sd32768;
    end
  end

  // cordic micro-rotation terms
  logic signed [CORDIC_W-1:0] dx1, dy1, dx2, dy2, at;
  assign dx1 = y1_r >>> iter_r;
  assign dy1 = x1_r >>> iter_r;
  assign dx2 = y2_r >>> iter_r;
  assign dy2 = x2_r >>> iter_r;
  assign at  = atan_turn(iter_r);

  // trig rounding to q1.14
  logic signed [CORDIC_W-1:0] xs1, ys1, xs2, ys2, xr1, yr1, xr2, yr2;
  always_comb begin
    xs1 = x1_r + TRIG_HALF;
    ys1 = y1_r + TRIG_HALF;
    xs2 = x2_r + TRIG_HALF;
    ys2 = y2_r + TRIG_HALF;
    xr1 = xs1 >>> 16;
    yr1 = ys1 >>> 16;
    xr2 = xs2 >>> 16;
    yr2 = ys2 >>> 16;
  end

  // errors and rounded jacobian
  logic signed [EPT_W-1:0] ept_x, ept_y;
  logic signed [EVT_W-1:0] evt_x, evt_y;
  logic signed [RJT_W-1:0] t00, t01, t10, t11;
  always_comb begin
    ept_x = (EPT_W'(item_r.target_x) <<< 14) - EPT_W'(px_r) + EP_HALF;
    ept_y = (EPT_W'(item_r.target_y) <<< 14) - EPT_W'(py_r) + EP_HALF;
    evt_x = (EVT_W'(item_r.target_vel_x) <<< 26) + EVT_W'(m1_r) + EVT_W'(m2_r) + EV_HALF;
    evt_y = (EVT_W'(item_r.target_vel_y) <<< 26) - EVT_W'(m3_r) - EVT_W'(m4_r) + EV_HALF;
    t00 = RJ_HALF - RJT_W'(py_r);
    t01 = RJ_HALF - RJT_W'(p2s_r);
    t10 = RJT_W'(px_r) + RJ_HALF;
    t11 = RJT_W'(p2c_r) + RJ_HALF;
  end

  // gain sums
  logic signed [GSUM_W-1:0] gsum_x, gsum_y;
  always_comb begin
    gsum_x = GSUM_W'(gx1_r) + GSUM_W'(gx2_r) + GSUM_W'(gx3_r) + GSUM_W'(gx4_r) + ACC_HALF;
    gsum_y = GSUM_W'(gy1_r) + GSUM_W'(gy2_r) + GSUM_W'(gy3_r) + GSUM_W'(gy4_r) + ACC_HALF;
  end

  // split of the task acceleration for the numerator products
  logic signed [SPLIT_W-1:0] ax_hi, ay_hi;
  logic signed [SPLIT_W:0] ax_lo, ay_lo;
  assign ax_hi = ax_r[ACC_W-1:SPLIT_W];
  assign ay_hi = ay_r[ACC_W-1:SPLIT_W];
  assign ax_lo = {1'b0, ax_r[SPLIT_W-1:0]};
  assign ay_lo = {1'b0, ay_r[SPLIT_W-1:0]};

  logic signed [NUM_W-1:0] hi1, hi2, num1, num2;
  always_comb begin
    hi1 = NUM_W'(h11x_r) - NUM_W'(h01y_r);
    hi2 = NUM_W'(h00y_r) - NUM_W'(h10x_r);
    num1 = (hi1 <<< SPLIT_W) + NUM_W'(l11x_r) - NUM_W'(l01y_r);
    num2 = (hi2 <<< SPLIT_W) + NUM_W'(l00y_r) - NUM_W'(l10x_r);
  end

  // input holding register and sequencing
  assign in_stall  = hold_valid_r;
  assign accept    = in_valid && !hold_valid_r;
  assign start     = (state_r == F_IDLE) && hold_valid_r;
  assign job_valid = (state_r == F_PUSH);
  assign job       = job_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt = iter_r;
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (start) begin
      hold_valid_nxt = 1'b0;
    end
    case (state_r)
      F_IDLE: begin
        iter_nxt = '0;
        if (hold_valid_r) state_nxt = F_CORDIC;
      end
      F_CORDIC: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = F_TRIG;
      end
      F_TRIG: state_nxt = F_PROD;
      F_PROD: state_nxt = F_VEL;
      F_VEL:  state_nxt = F_ERR;
      F_ERR:  state_nxt = F_GAIN;
      F_GAIN: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_NUMP;
      F_NUMP: state_nxt = F_NUM;
      F_NUM:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!job_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      iter_r <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r <= iter_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) hold_r <= in_data;
    case (state_r)
      F_IDLE: begin
        item_r <= hold_r;
        x1_r <= CORDIC_X0;
        y1_r <= '0;
        z1_r <= {{(CORDIC_W-33){a1_fold[16]}}, a1_fold, 16'd0};
        x2_r <= CORDIC_X0;
        y2_r <= '0;
        z2_r <= {{(CORDIC_W-33){a2_fold[16]}}, a2_fold, 16'd0};
        flip1_r <= fold1;
        flip2_r <= fold2;
      end
      F_CORDIC: begin
        if (!z1_r[CORDIC_W-1]) begin
          x1_r <= x1_r - dx1;
          y1_r <= y1_r + dy1;
          z1_r <= z1_r - at;
        end else begin
          x1_r <= x1_r + dx1;
          y1_r <= y1_r - dy1;
          z1_r <= z1_r + at;
        end
        if (!z2_r[CORDIC_W-1]) begin
          x2_r <= x2_r - dx2;
          y2_r <= y2_r + dy2;
          z2_r <= z2_r - at;
        end else begin
          x2_r <= x2_r + dx2;
          y2_r <= y2_r - dy2;
          z2_r <= z2_r + at;
        end
      end
      F_TRIG: begin
        c1_r  <= flip1_r ? -xr1[TRIG_W-1:0] : xr1[TRIG_W-1:0];
        s1_r  <= flip1_r ? -yr1[TRIG_W-1:0] : yr1[TRIG_W-1:0];
        c12_r <= flip2_r ? -xr2[TRIG_W-1:0] : xr2[TRIG_W-1:0];
        s12_r <= flip2_r ? -yr2[TRIG_W-1:0] : yr2[TRIG_W-1:0];
        rsum_r <= 17'(item_r.joint_rate_1) + 17'(item_r.joint_rate_2);
      end
      F_PROD: begin
        p1c_r <= L1 * c1_r;
        p1s_r <= L1 * s1_r;
        p2c_r <= L2 * c12_r;
        p2s_r <= L2 * s12_r;
      end
      F_VEL: begin
        px_r <= PSUM_W'(p1c_r) + PSUM_W'(p2c_r);
        py_r <= PSUM_W'(p1s_r) + PSUM_W'(p2s_r);
        m1_r <= p1s_r * item_r.joint_rate_1;
        m2_r <= p2s_r * rsum_r;
        m3_r <= p1c_r * item_r.joint_rate_1;
        m4_r <= p2c_r * rsum_r;
      end
      F_ERR: begin
        epx_r <= ept_x[EPT_W-1:10];
        epy_r <= ept_y[EPT_W-1:10];
        evx_r <= evt_x[EVT_W-1:22];
        evy_r <= evt_y[EVT_W-1:22];
        r00_r <= t00[RJT_W-1:10];
        r01_r <= t01[RJT_W-1:10];
        r10_r <= t10[RJT_W-1:10];
        r11_r <= t11[RJT_W-1:10];
      end
      F_GAIN: begin
        gx1_r <= gains.kxx * epx_r;
        gx2_r <= gains.kxy * epy_r;
        gx3_r <= gains.dxx * evx_r;
        gx4_r <= gains.dxy * evy_r;
        gy1_r <= gains.kyx * epx_r;
        gy2_r <= gains.kyy * epy_r;
        gy3_r <= gains.dyx * evx_r;
        gy4_r <= gains.dyy * evy_r;
        dp1_r <= r00_r * r11_r;
        dp2_r <= r01_r * r10_r;
      end
      F_SUM: begin
        ax_r <= gsum_x[GSUM_W-1:8];
        ay_r <= gsum_y[GSUM_W-1:8];
        det_r <= DET_W'(dp1_r) - DET_W'(dp2_r);
      end
      F_NUMP: begin
        h11x_r <= r11_r * ax_hi;
        h01y_r <= r01_r * ay_hi;
        h00y_r <= r00_r * ay_hi;
        h10x_r <= r10_r * ax_hi;
        l11x_r <= r11_r * ax_lo;
        l01y_r <= r01_r * ay_lo;
        l00y_r <= r00_r * ay_lo;
        l10x_r <= r10_r * ax_lo;
      end
      F_NUM: begin
        job_r.num1 <= num1;
        job_r.num2 <= num2;
        job_r.det <= det_r;
        job_r.singular <= (det_r == '0);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/tspd_fifo.sv
module tspd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tspd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output tspd_pkg::job_t pop_job,
  output logic           not_empty
);
  import tspd_pkg::*;

  localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

  job_t mem_r [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full      = (count_r == CNT_W'(JOB_QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(JOB_QUEUE_DEPTH))
    else $error("job queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (full && push && !pop) |=> full && (count_r == $past(count_r)))
    else $error("job queue took a request while full");

endmodule

FILE: rtl/tspd_back.sv
module tspd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_pop,
  input  tspd_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_stall,
  output tspd_pkg::out_item_t out_data
);
  import tspd_pkg::*;

  localparam int DEN_W = DET_W;
  localparam int CNT_W = $clog2(QUO_W);

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r;

  logic [NUM_W-1:0] n1_r, n2_r;
  logic [DEN_W-1:0] d_r;
  logic neg1_r, neg2_r, sing_r, ovf1_r, ovf2_r;
  logic [DIVIDEND_W-1:0] rem1_r, rem2_r, dsh_r;
  logic [QUO_W-1:0] q1_r, q2_r;
  logic load_out;

  // magnitudes and signs of the request
  logic [NUM_W-1:0] abs1, abs2;
  logic [DEN_W-1:0] absd;
  always_comb begin
    abs1 = job.num1[NUM_W-1] ? NUM_W'(-job.num1) : NUM_W'(job.num1);
    abs2 = job.num2[NUM_W-1] ? NUM_W'(-job.num2) : NUM_W'(job.num2);
    absd = job.det[DET_W-1] ? DEN_W'(-job.det) : DEN_W'(job.det);
  end

  // restoring divide step
  logic ge1, ge2;
  assign ge1 = (rem1_r >= dsh_r);
  assign ge2 = (rem2_r >= dsh_r);

  // saturated signed result
  logic [CMD_W-1:0] mag1, mag2, cmd1, cmd2;
  always_comb begin
    mag1 = {1'b0, q1_r};
    mag2 = {1'b0, q2_r};
    if (neg1_r) cmd1 = ovf1_r ? CMD_MIN : -mag1;
    else        cmd1 = ovf1_r ? CMD_MAX : mag1;
    if (neg2_r) cmd2 = ovf2_r ? CMD_MIN : -mag2;
    else        cmd2 = ovf2_r ? CMD_MAX : mag2;
  end

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign load_out  = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) out_valid_nxt = 1'b1;
    case (state_r)
      B_IDLE: begin
        if (job_valid) state_nxt = B_CHECK;
      end
      B_CHECK: begin
        cnt_nxt = '0;
        state_nxt = sing_r ? B_OUT : B_DIV;
      end
      B_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (load_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // divider datapath, both quotients share the shifted divisor
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        n1_r <= abs1;
        n2_r <= abs2;
        d_r <= absd;
        neg1_r <= job.num1[NUM_W-1] ^ job.det[DET_W-1];
        neg2_r <= job.num2[NUM_W-1] ^ job.det[DET_W-1];
        sing_r <= job.singular;
      end
      B_CHECK: begin
        ovf1_r <= (n1_r >= NUM_W'({d_r, 15'd0}));
        ovf2_r <= (n2_r >= NUM_W'({d_r, 15'd0}));
        rem1_r <= DIVIDEND_W'({n1_r, 16'd0});
        rem2_r <= DIVIDEND_W'({n2_r, 16'd0});
        dsh_r <= DIVIDEND_W'({d_r, 30'd0});
        q1_r <= '0;
        q2_r <= '0;
      end
      B_DIV: begin
        if (ge1) rem1_r <= rem1_r - dsh_r;
        if (ge2) rem2_r <= rem2_r - dsh_r;
        q1_r <= {q1_r[QUO_W-2:0], ge1};
        q2_r <= {q2_r[QUO_W-2:0], ge2};
        dsh_r <= dsh_r >> 1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_r.singular <= sing_r;
      out_r.accel_cmd_1 <= sing_r ? '0 : cmd1;
      out_r.accel_cmd_2 <= sing_r ? '0 : cmd2;
    end
  end

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.singular) |-> (out_r.accel_cmd_1 == '0 && out_r.accel_cmd_2 == '0))
    else $error("singular result carries a nonzero command");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == B_CHECK))
    else $error("request taken from queue without starting work");

endmodule

FILE: rtl/task_space_pd_two_link_arm.sv
// Task-space PD controller for a planar two-link arm. One request carries the
// joint angles and rates and the Cartesian target; one result returns two
// saturated Q16.16 joint commands and a singular flag (commands zero when the
// rounded Jacobian determinant is zero). The front end runs a 16-step CORDIC
// for both angles and then eight arithmetic steps, and holds one more request
// while busy; a two-entry queue feeds the back end, whose one-bit-a-cycle
// restoring divider is skipped for a singular request, so the front end works
// on the next request while the back end divides. Gains are written over the
// APB port at byte address 4*i and must only change while idle.
module task_space_pd_two_link_arm #(
  parameter int LINK1_LENGTH = tspd_pkg::LINK1_LENGTH_DEF,
  parameter int LINK2_LENGTH = tspd_pkg::LINK2_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tspd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tspd_pkg::out_item_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tspd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tspd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tspd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import tspd_pkg::*;

  logic [GAIN_W-1:0] regs_r [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_write;
  gains_t gains;
  job_t push_job, pop_job;
  logic job_valid, job_full, job_pop, job_ready;

  // gain register file
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = CFG_DATA_W'(regs_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= REG_RESET;
    end else if (cfg_write) begin
      regs_r[reg_idx] <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  always_comb begin
    gains.kxx = regs_r[REG_STIFF_XX];
    gains.kxy = regs_r[REG_STIFF_XY];
    gains.kyx = regs_r[REG_STIFF_YX];
    gains.kyy = regs_r[REG_STIFF_YY];
    gains.dxx = regs_r[REG_DAMP_XX];
    gains.dxy = regs_r[REG_DAMP_XY];
    gains.dyx = regs_r[REG_DAMP_YX];
    gains.dyy = regs_r[REG_DAMP_YY];
  end

  // kinematics and gains
  tspd_front #(
    .LINK1_LENGTH(LINK1_LENGTH),
    .LINK2_LENGTH(LINK2_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .gains    (gains),
    .job_valid(job_valid),
    .job_full (job_full),
    .job      (push_job)
  );

  // decoupling queue
  tspd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .not_empty(job_ready)
  );

  // inverse mapping and division
  tspd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(job_ready),
    .job_pop  (job_pop),
    .job      (pop_job),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
